### sv/dwsp_pkg.sv
// Package for the dual wheel speed PID block.
// It holds field widths, reset values, register and mode codes, and shared types.
// No dependencies.
package dwsp_pkg;

  // Default parameter values for the top level.
  localparam int SPEED_WIDTH_DEF     = 16;
  localparam int FRAC_BITS_DEF       = 12;
  localparam int DUTY_FULL_SCALE_DEF = 100;

  // Fixed field widths.
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 17;
  localparam int CEIL_W     = 13;
  localparam int DUTY_W     = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd819;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd614;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd328;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 17'd24576;
  localparam logic [CEIL_W-1:0]  CEILING_RST   = 13'd4096;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_RIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CEILING  = 3'd7;

  // Input word modes.
  localparam logic [MODE_W-1:0] MODE_TICK      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLR_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR_RIGHT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLR_BOTH  = 2'd3;

  // One wheel's gain set.
  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gain_set_t;

  // Pipeline control handed from the top level to each lane.
  typedef struct packed {
    logic load1;  // tick word accepted: update loop state and fill stage 1
    logic clear;  // clear word accepted for this wheel
    logic adv2;   // stage 2 takes from stage 1
    logic adv3;   // stage 3 takes from stage 2
  } lane_ctl_t;

  // Elaboration-time maximum.
  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/dual_wheel_speed_pid.sv
// Channel  | Dir | Handshake            | Payload
// in_      | in  | in_valid / in_stall  | mode, targets, measured speeds, reverse flags
// out_     | out | out_valid / out_stall| duty and loop output per wheel
// cfg_     | in  | cfg_we               | cfg_index, cfg_wdata
//
// One word is accepted per cycle while in_stall is low; a tick word's result passes through
// lane stages two and three and then the output register, as stage one loads at the edge
// that accepts it. The rate is set by the integral and previous-error update, which
// completes in the accept cycle.
// Clear words update loop state and leave no result. Reset is synchronous and
// restores gains and limits; out_stall backs up through the stages to in_stall.
// Depends on dwsp_pkg, dwsp_lane and dwsp_merge.
module dual_wheel_speed_pid #(
  parameter int SPEED_WIDTH     = dwsp_pkg::SPEED_WIDTH_DEF,
  parameter int FRAC_BITS       = dwsp_pkg::FRAC_BITS_DEF,
  parameter int DUTY_FULL_SCALE = dwsp_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dwsp_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [SPEED_WIDTH-1:0]        in_target_left,
  input  logic signed [SPEED_WIDTH-1:0]        in_target_right,
  input  logic signed [SPEED_WIDTH-1:0]        in_measured_left,
  input  logic signed [SPEED_WIDTH-1:0]        in_measured_right,
  input  logic                                 in_reverse_left,
  input  logic                                 in_reverse_right,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dwsp_pkg::DUTY_W-1:0]   out_duty_left,
  output logic signed [dwsp_pkg::DUTY_W-1:0]   out_duty_right,
  output logic [dwsp_pkg::CEIL_W-1:0]          out_loop_out_left,
  output logic [dwsp_pkg::CEIL_W-1:0]          out_loop_out_right,
  input  logic                                 cfg_we,
  input  logic [dwsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import dwsp_pkg::*;

  localparam int DFS_W = $clog2(DUTY_FULL_SCALE + 1);

  // Configuration registers.
  gain_set_t          gain_l_r;
  gain_set_t          gain_r_r;
  logic [LIMIT_W-1:0] int_limit_r;
  logic [CEIL_W-1:0]  ceiling_r;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic en1, en2, en3, take;
  logic acc_word, tick;

  lane_ctl_t          ctl_l;
  lane_ctl_t          ctl_r;
  logic [CEIL_W-1:0]  lo_l, lo_r;
  logic               rev_l, rev_r;
  logic [DFS_W-1:0]   rmag_l, rmag_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_l_r    <= '{p: GAIN_P_RST, i: GAIN_I_RST, d: GAIN_D_RST};
      gain_r_r    <= '{p: GAIN_P_RST, i: GAIN_I_RST, d: GAIN_D_RST};
      int_limit_r <= INT_LIMIT_RST;
      ceiling_r   <= CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P_LEFT:  gain_l_r.p  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I_LEFT:  gain_l_r.i  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D_LEFT:  gain_l_r.d  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_P_RIGHT: gain_r_r.p  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I_RIGHT: gain_r_r.i  <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D_RIGHT: gain_r_r.d  <= cfg_wdata[GAIN_W-1:0];
        REG_INT_LIMIT:    int_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_OUT_CEILING:  ceiling_r   <= cfg_wdata[CEIL_W-1:0];
      endcase
    end
  end

  // Stage advance chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en3      = !v3_r || take;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    in_stall = !en1;
    acc_word = in_valid && en1;
    tick     = acc_word && (in_mode == MODE_TICK);
    v1_nxt   = en1 ? tick : v1_r;
    v2_nxt   = en2 ? v1_r : v2_r;
    v3_nxt   = en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Per-lane control.
  always_comb begin
    ctl_l.load1 = tick;
    ctl_l.clear = acc_word && (in_mode == MODE_CLR_LEFT || in_mode == MODE_CLR_BOTH);
    ctl_l.adv2  = en2;
    ctl_l.adv3  = en3;
    ctl_r.load1 = tick;
    ctl_r.clear = acc_word && (in_mode == MODE_CLR_RIGHT || in_mode == MODE_CLR_BOTH);
    ctl_r.adv2  = en2;
    ctl_r.adv3  = en3;
  end

  dwsp_lane #(
    .SPEED_WIDTH     (SPEED_WIDTH),
    .FRAC_BITS       (FRAC_BITS),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_l),
    .gain        (gain_l_r),
    .int_limit   (int_limit_r),
    .out_ceiling (ceiling_r),
    .target      (in_target_left),
    .measured    (in_measured_left),
    .reverse     (in_reverse_left),
    .loop_out    (lo_l),
    .rev_o       (rev_l),
    .rev_mag     (rmag_l)
  );

  dwsp_lane #(
    .SPEED_WIDTH     (SPEED_WIDTH),
    .FRAC_BITS       (FRAC_BITS),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_r),
    .gain        (gain_r_r),
    .int_limit   (int_limit_r),
    .out_ceiling (ceiling_r),
    .target      (in_target_right),
    .measured    (in_measured_right),
    .reverse     (in_reverse_right),
    .loop_out    (lo_r),
    .rev_o       (rev_r),
    .rev_mag     (rmag_r)
  );

  dwsp_merge #(
    .FRAC_BITS       (FRAC_BITS),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_vld             (v3_r),
    .take               (take),
    .lo_left            (lo_l),
    .lo_right           (lo_r),
    .rev_left           (rev_l),
    .rev_right          (rev_r),
    .rmag_left          (rmag_l),
    .rmag_right         (rmag_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_duty_left      (out_duty_left),
    .out_duty_right     (out_duty_right),
    .out_loop_out_left  (out_loop_out_left),
    .out_loop_out_right (out_loop_out_right)
  );

endmodule

### sv/dwsp_lane.sv
// One wheel's PID lane: loop state, error and integral update, products and clamp.
// Three pipeline stages; the loop state updates in the cycle a tick word is accepted.
// Depends on dwsp_pkg.
module dwsp_lane #(
  parameter int SPEED_WIDTH     = dwsp_pkg::SPEED_WIDTH_DEF,
  parameter int FRAC_BITS       = dwsp_pkg::FRAC_BITS_DEF,
  parameter int DUTY_FULL_SCALE = dwsp_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  dwsp_pkg::lane_ctl_t                        ctl,
  input  dwsp_pkg::gain_set_t                        gain,
  input  logic [dwsp_pkg::LIMIT_W-1:0]               int_limit,
  input  logic [dwsp_pkg::CEIL_W-1:0]                out_ceiling,
  input  logic signed [SPEED_WIDTH-1:0]              target,
  input  logic signed [SPEED_WIDTH-1:0]              measured,
  input  logic                                       reverse,
  output logic [dwsp_pkg::CEIL_W-1:0]                loop_out,
  output logic                                       rev_o,
  output logic [$clog2(DUTY_FULL_SCALE+1)-1:0]       rev_mag
);
  import dwsp_pkg::*;

  localparam int EW    = SPEED_WIDTH + 1;
  localparam int IW    = LIMIT_W + 1;
  localparam int AW    = max_int(IW, EW) + 1;
  localparam int DEW   = EW + 1;
  localparam int GW1   = GAIN_W + 1;
  localparam int PPW   = EW + GW1;
  localparam int PIW   = IW + GW1;
  localparam int PDW   = DEW + GW1;
  localparam int SUMW  = max_int(max_int(PPW, PIW), PDW) + 2;
  localparam int SHW   = SUMW - FRAC_BITS;
  localparam int CMPW  = max_int(SHW, CEIL_W);
  localparam int DFS_W = $clog2(DUTY_FULL_SCALE + 1);
  localparam int RPW   = SPEED_WIDTH + DFS_W;

  // Loop state.
  logic signed [EW-1:0]  perr_r;
  logic signed [IW-1:0]  integ_r;

  // Stage 1.
  logic signed [EW-1:0]    e1_r;
  logic signed [IW-1:0]    i1_r;
  logic signed [DEW-1:0]   de1_r;
  logic [SPEED_WIDTH-1:0]  mag1_r;
  logic                    rev1_r;

  // Stage 2.
  logic signed [PPW-1:0]   pp2_r;
  logic signed [PIW-1:0]   pi2_r;
  logic signed [PDW-1:0]   pd2_r;
  logic [DFS_W-1:0]        rmag2_r;
  logic                    rev2_r;

  // Stage 3.
  logic [CEIL_W-1:0]       lo3_r;
  logic [DFS_W-1:0]        rmag3_r;
  logic                    rev3_r;

  logic signed [EW-1:0]    err;
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    lim_pos;
  logic signed [AW-1:0]    lim_neg;
  logic signed [AW-1:0]    acc_clamped;
  logic signed [IW-1:0]    integ_nxt;
  logic signed [DEW-1:0]   de;
  logic signed [SPEED_WIDTH:0] tgt_ext;
  logic signed [SPEED_WIDTH:0] tgt_abs;
  logic signed [GAIN_W:0]  gp_s;
  logic signed [GAIN_W:0]  gi_s;
  logic signed [GAIN_W:0]  gd_s;
  logic [RPW-1:0]          rprod;
  logic [RPW-1:0]          rshift;
  logic [DFS_W-1:0]        rmag;
  logic signed [SUMW-1:0]  sum;
  logic [SHW-1:0]          sh;
  logic                    sum_pos;
  logic [CEIL_W-1:0]       lo;

  // Error, clamped integral and error difference.
  always_comb begin
    err         = EW'(target) - EW'(measured);
    acc         = AW'(integ_r) + AW'(err);
    lim_pos     = signed'(AW'(int_limit));
    lim_neg     = -lim_pos;
    if (acc > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc;
    end
    integ_nxt   = (gain.i != '0) ? IW'(acc_clamped) : integ_r;
    de          = DEW'(err) - DEW'(perr_r);
    tgt_ext     = (SPEED_WIDTH+1)'(target);
    tgt_abs     = (tgt_ext < 0) ? -tgt_ext : tgt_ext;
  end

  // Loop state: updated on a tick, zeroed on a clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perr_r  <= '0;
      integ_r <= '0;
    end else if (ctl.load1) begin
      perr_r  <= err;
      integ_r <= integ_nxt;
    end else if (ctl.clear) begin
      perr_r  <= '0;
      integ_r <= '0;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      e1_r   <= err;
      i1_r   <= integ_nxt;
      de1_r  <= de;
      mag1_r <= tgt_abs[SPEED_WIDTH-1:0];
      rev1_r <= reverse;
    end
  end

  // Stage 2: the three gain products and the open-loop reverse duty.
  always_comb begin
    gp_s   = signed'({1'b0, gain.p});
    gi_s   = signed'({1'b0, gain.i});
    gd_s   = signed'({1'b0, gain.d});
    rprod  = RPW'(mag1_r) * RPW'(DUTY_FULL_SCALE);
    rshift = rprod >> FRAC_BITS;
    rmag   = (rshift > RPW'(DUTY_FULL_SCALE)) ? DFS_W'(DUTY_FULL_SCALE)
                                               : rshift[DFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      pp2_r   <= PPW'(gp_s) * PPW'(e1_r);
      pi2_r   <= PIW'(gi_s) * PIW'(i1_r);
      pd2_r   <= PDW'(gd_s) * PDW'(de1_r);
      rmag2_r <= rmag;
      rev2_r  <= rev1_r;
    end
  end

  // Stage 3: sum, drop the fraction, clamp to 0..ceiling.
  always_comb begin
    sum     = SUMW'(pp2_r) + SUMW'(pi2_r) + SUMW'(pd2_r);
    sh      = sum[SUMW-1:FRAC_BITS];
    sum_pos = !sum[SUMW-1] && (sum != '0);
    if (!sum_pos) begin
      lo = '0;
    end else if (CMPW'(sh) > CMPW'(out_ceiling)) begin
      lo = out_ceiling;
    end else begin
      lo = sh[CEIL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      lo3_r   <= lo;
      rmag3_r <= rmag2_r;
      rev3_r  <= rev2_r;
    end
  end

  assign loop_out = lo3_r;
  assign rev_o    = rev3_r;
  assign rev_mag  = rmag3_r;

endmodule

### sv/dwsp_merge.sv
// Merge stage: turns both lanes' loop outputs into duty words and holds the result word.
// Owns the output register and its handshake.
// Depends on dwsp_pkg.
module dwsp_merge #(
  parameter int FRAC_BITS       = dwsp_pkg::FRAC_BITS_DEF,
  parameter int DUTY_FULL_SCALE = dwsp_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  output logic                                  take,
  input  logic [dwsp_pkg::CEIL_W-1:0]           lo_left,
  input  logic [dwsp_pkg::CEIL_W-1:0]           lo_right,
  input  logic                                  rev_left,
  input  logic                                  rev_right,
  input  logic [$clog2(DUTY_FULL_SCALE+1)-1:0]  rmag_left,
  input  logic [$clog2(DUTY_FULL_SCALE+1)-1:0]  rmag_right,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dwsp_pkg::DUTY_W-1:0]    out_duty_left,
  output logic signed [dwsp_pkg::DUTY_W-1:0]    out_duty_right,
  output logic [dwsp_pkg::CEIL_W-1:0]           out_loop_out_left,
  output logic [dwsp_pkg::CEIL_W-1:0]           out_loop_out_right
);
  import dwsp_pkg::*;

  localparam int DFS_W = $clog2(DUTY_FULL_SCALE + 1);
  localparam int FPW   = CEIL_W + DFS_W;
  localparam int DW    = max_int(DUTY_W, DFS_W + 1);

  logic                     valid_r;
  logic signed [DUTY_W-1:0] duty_l_r;
  logic signed [DUTY_W-1:0] duty_r_r;
  logic [CEIL_W-1:0]        lo_l_r;
  logic [CEIL_W-1:0]        lo_r_r;
  logic signed [DW-1:0]     duty_l;
  logic signed [DW-1:0]     duty_r;

  // Forward duty magnitude: out * full scale, fraction dropped, saturated.
  function automatic logic [DFS_W-1:0] fwd_mag(input logic [CEIL_W-1:0] lo);
    logic [FPW-1:0] prod;
    logic [FPW-1:0] shifted;
    prod    = FPW'(lo) * FPW'(DUTY_FULL_SCALE);
    shifted = prod >> FRAC_BITS;
    return (shifted > FPW'(DUTY_FULL_SCALE)) ? DFS_W'(DUTY_FULL_SCALE)
                                              : shifted[DFS_W-1:0];
  endfunction

  // Signed duty per wheel: a reverse wheel reports the negated open-loop value.
  always_comb begin
    duty_l = rev_left  ? -DW'(rmag_left)  : DW'(fwd_mag(lo_left));
    duty_r = rev_right ? -DW'(rmag_right) : DW'(fwd_mag(lo_right));
  end

  assign take = !valid_r || !out_stall;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      duty_l_r <= duty_l[DUTY_W-1:0];
      duty_r_r <= duty_r[DUTY_W-1:0];
      lo_l_r   <= lo_left;
      lo_r_r   <= lo_right;
    end
  end

  assign out_valid          = valid_r;
  assign out_duty_left      = duty_l_r;
  assign out_duty_right     = duty_r_r;
  assign out_loop_out_left  = lo_l_r;
  assign out_loop_out_right = lo_r_r;

endmodule

### sv/dwsp_chk.sv
// Port-level checker for the dual wheel speed PID block, bound to the top level.
// Depends on dwsp_pkg and dual_wheel_speed_pid.
module dwsp_chk #(
  parameter int DUTY_FULL_SCALE = dwsp_pkg::DUTY_FULL_SCALE_DEF
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        out_valid,
  input logic                                        out_stall,
  input logic signed [dwsp_pkg::DUTY_W-1:0]          out_duty_left,
  input logic signed [dwsp_pkg::DUTY_W-1:0]          out_duty_right,
  input logic [dwsp_pkg::CEIL_W-1:0]                 out_loop_out_left,
  input logic [dwsp_pkg::CEIL_W-1:0]                 out_loop_out_right
);
  import dwsp_pkg::*;

  localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(DUTY_FULL_SCALE);
  localparam logic signed [DUTY_W-1:0] DUTY_MIN = -DUTY_W'(DUTY_FULL_SCALE);

  // A held result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_left) &&
      $stable(out_duty_right) && $stable(out_loop_out_left) && $stable(out_loop_out_right))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // Duty stays within full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_left <= DUTY_MAX && out_duty_left >= DUTY_MIN &&
      out_duty_right <= DUTY_MAX && out_duty_right >= DUTY_MIN)
    else $error("duty out of range");

  // A forward duty is positive only when the loop output is.
  a_duty_needs_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty_left > 0 || out_duty_right > 0) |->
      (out_duty_left <= 0 || out_loop_out_left != '0) &&
      (out_duty_right <= 0 || out_loop_out_right != '0))
    else $error("positive duty with zero loop output");

endmodule

bind dual_wheel_speed_pid dwsp_chk #(.DUTY_FULL_SCALE(DUTY_FULL_SCALE)) u_dwsp_chk (.*);
